// File: hdl/bdq_pkg.sv
// Package: sizes, codes, cell control type and word conversions for the deque.
package bdq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int DATA_BITS = 32;
  localparam int CAP_BITS  = 5;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int LIM_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  localparam logic [1:0] OP_PUSH_LEFT  = 2'd0;
  localparam logic [1:0] OP_PUSH_RIGHT = 2'd1;
  localparam logic [1:0] OP_POP_LEFT   = 2'd2;
  localparam logic [1:0] OP_POP_RIGHT  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef struct packed {
    logic from_left;
    logic from_right;
    logic load;
    logic sel;
  } cell_ctl_t;

  function automatic word_t to_word(data_t v);
    word_t w;
    w = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (i < DATA_BITS) begin
        w[i] = v[i];
      end
    end
    return w;
  endfunction

  function automatic data_t from_word(word_t w);
    data_t v;
    v = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      if (i < WORD_BITS) begin
        v[i] = w[i];
      end
    end
    return v;
  endfunction

endpackage

// File: hdl/bounded_double_ended_queue.sv
// Top level: bounded deque built as a row of shifting cells, left end at cell zero.
// Takes one operation per clock: busy never rises, and the result of a beat taken at
// one edge is shown with out_valid for the next cycle only, so the receiver must take
// it then. The rate is set by the cell row, which shifts or loads all cells in the same
// cycle the count is updated. Capacity may be written through cfg_ only while idle;
// values above the row length act as the row length, zero refuses every push.
module bounded_double_ended_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_operation,
  input  logic signed [31:0]           in_push_value,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic signed [31:0]           out_data_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bdq_pkg::CAP_BITS-1:0] cfg_capacity
);

  localparam int N = bdq_pkg::DEPTH;

  logic [bdq_pkg::CAP_BITS-1:0] cap_r;
  bdq_pkg::cnt_t                cnt_r;
  bdq_pkg::cnt_t                cnt_nxt;
  logic                         out_valid_r;
  logic [1:0]                   status_r;
  logic [1:0]                   status_nxt;
  bdq_pkg::data_t               data_r;
  bdq_pkg::data_t               data_nxt;

  logic [bdq_pkg::LIM_BITS-1:0] cap_ext;
  logic [bdq_pkg::LIM_BITS-1:0] cnt_ext;
  logic [bdq_pkg::LIM_BITS-1:0] lim;
  logic                         accept;
  logic                         full;
  logic                         empty;
  logic                         do_pushl;
  logic                         do_pushr;
  logic                         do_popl;
  logic                         do_popr;
  bdq_pkg::word_t               push_word;
  bdq_pkg::word_t               pop_right_word;

  bdq_pkg::cell_ctl_t           ctl   [N];
  bdq_pkg::word_t               words [N];
  bdq_pkg::word_t               taps  [N];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign push_word = bdq_pkg::to_word(in_push_value);

  assign cap_ext = bdq_pkg::LIM_BITS'(cap_r);
  assign cnt_ext = bdq_pkg::LIM_BITS'(cnt_r);
  assign lim     = (cap_ext > bdq_pkg::LIM_BITS'(N)) ? bdq_pkg::LIM_BITS'(N) : cap_ext;
  assign full    = cnt_ext >= lim;
  assign empty   = cnt_r == '0;

  assign do_pushl = accept && in_operation == bdq_pkg::OP_PUSH_LEFT  && !full;
  assign do_pushr = accept && in_operation == bdq_pkg::OP_PUSH_RIGHT && !full;
  assign do_popl  = accept && in_operation == bdq_pkg::OP_POP_LEFT   && !empty;
  assign do_popr  = accept && in_operation == bdq_pkg::OP_POP_RIGHT  && !empty;

  for (genvar i = 0; i < N; i++) begin : g_cell
    bdq_pkg::word_t left_w;
    bdq_pkg::word_t right_w;

    assign ctl[i].from_left  = do_pushl;
    assign ctl[i].from_right = do_popl;
    assign ctl[i].load       = do_pushr && cnt_r == bdq_pkg::CNT_BITS'(i);
    assign ctl[i].sel        = cnt_r == bdq_pkg::CNT_BITS'(i + 1);

    if (i == 0) begin : g_lend
      assign left_w = push_word;
    end else begin : g_lmid
      assign left_w = words[i-1];
    end
    if (i == N - 1) begin : g_rend
      assign right_w = '0;
    end else begin : g_rmid
      assign right_w = words[i+1];
    end

    bdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .left_word  (left_w),
      .right_word (right_w),
      .load_word  (push_word),
      .word       (words[i]),
      .tap        (taps[i])
    );
  end

  always_comb begin
    pop_right_word = '0;
    for (int i = 0; i < N; i++) begin
      pop_right_word = pop_right_word | taps[i];
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = bdq_pkg::ST_DONE;
    data_nxt   = '0;
    case (in_operation)
      bdq_pkg::OP_PUSH_LEFT, bdq_pkg::OP_PUSH_RIGHT: begin
        if (full) begin
          status_nxt = bdq_pkg::ST_FULL;
        end else begin
          data_nxt = bdq_pkg::from_word(push_word);
          cnt_nxt  = cnt_r + bdq_pkg::CNT_BITS'(1);
        end
      end
      bdq_pkg::OP_POP_LEFT: begin
        if (empty) begin
          status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          data_nxt = bdq_pkg::from_word(words[0]);
          cnt_nxt  = cnt_r - bdq_pkg::CNT_BITS'(1);
        end
      end
      default: begin
        if (empty) begin
          status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          data_nxt = bdq_pkg::from_word(pop_right_word);
          cnt_nxt  = cnt_r - bdq_pkg::CNT_BITS'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= bdq_pkg::CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_data_value = data_r;

endmodule

// File: hdl/bdq_cell.sv
// One storage cell of the deque row: shifts from either neighbor or loads a new word.
module bdq_cell (
  input  logic              clk,
  input  bdq_pkg::cell_ctl_t ctl,
  input  bdq_pkg::word_t    left_word,
  input  bdq_pkg::word_t    right_word,
  input  bdq_pkg::word_t    load_word,
  output bdq_pkg::word_t    word,
  output bdq_pkg::word_t    tap
);

  bdq_pkg::word_t word_r;
  bdq_pkg::word_t word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.from_left) begin
      word_nxt = left_word;
    end else if (ctl.from_right) begin
      word_nxt = right_word;
    end else if (ctl.load) begin
      word_nxt = load_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  assign tap  = ctl.sel ? word_r : '0;

endmodule

// File: hdl/bdq_checker.sv
// Checker: port-level properties of the deque, bound to the top level.
module bdq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   in_operation,
  input logic signed [31:0]           in_push_value,
  input logic                         out_valid,
  input logic [1:0]                   out_status,
  input logic signed [31:0]           out_data_value
);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted beat gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted beat");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bdq_pkg::ST_DONE || out_status == bdq_pkg::ST_FULL ||
                   out_status == bdq_pkg::ST_EMPTY))
    else $error("bad status code");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bdq_pkg::ST_DONE) |-> out_data_value == 32'sd0)
    else $error("refused beat carries data");

  a_push_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == bdq_pkg::OP_PUSH_RIGHT) ##1
    (out_status == bdq_pkg::ST_DONE) |-> out_data_value == $past(in_push_value))
    else $error("push result does not echo the word");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (.*);
